// ===== src/rgdf_pkg.sv =====
// Shared types and constants of the radar gate deglitch flagger.
`timescale 1ns / 1ps

package rgdf_pkg;

  // Radius used when the radius register holds zero.
  localparam int DEFAULT_RADIUS = 3;

  // Register indexes on the configuration port (byte address / 4).
  localparam logic [2:0] REG_RADIUS    = 3'd0;
  localparam logic [2:0] REG_MIN_GOOD  = 3'd1;
  localparam logic [2:0] REG_THRESHOLD = 3'd2;
  localparam logic [2:0] REG_BAD_VALUE = 3'd3;
  localparam logic [2:0] REG_CLIP_GATE = 3'd4;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  // Reset values of the registers.
  localparam logic [3:0]  RST_RADIUS    = 4'd3;
  localparam logic [4:0]  RST_MIN_GOOD  = 5'd0;
  localparam logic [15:0] RST_THRESHOLD = 16'd0;
  localparam logic [15:0] RST_BAD_VALUE = 16'h8000;
  localparam logic [15:0] RST_CLIP_GATE = 16'hFFFF;

  typedef struct packed {
    logic [3:0]         radius;
    logic [4:0]         min_good;
    logic [15:0]        threshold;
    logic signed [15:0] bad_value;
    logic [15:0]        clip_gate;
  } cfg_t;

endpackage

// ===== src/rgdf_cfg_regs.sv =====
// APB-style configuration registers of the deglitch flagger.
`timescale 1ns / 1ps

module rgdf_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [rgdf_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [rgdf_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [rgdf_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready,
  output rgdf_pkg::cfg_t                      cfg,
  output logic                                radius_wr
);

  rgdf_pkg::cfg_t cfg_r, cfg_nxt;
  logic           wr_en;
  logic [2:0]     reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = cfg_paddr[4:2];
  assign radius_wr  = wr_en && (reg_idx == rgdf_pkg::REG_RADIUS);
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        rgdf_pkg::REG_RADIUS:    cfg_nxt.radius    = cfg_pwdata[3:0];
        rgdf_pkg::REG_MIN_GOOD:  cfg_nxt.min_good  = cfg_pwdata[4:0];
        rgdf_pkg::REG_THRESHOLD: cfg_nxt.threshold = cfg_pwdata[15:0];
        rgdf_pkg::REG_BAD_VALUE: cfg_nxt.bad_value = cfg_pwdata[15:0];
        rgdf_pkg::REG_CLIP_GATE: cfg_nxt.clip_gate = cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      rgdf_pkg::REG_RADIUS:    cfg_prdata = 32'(cfg_r.radius);
      rgdf_pkg::REG_MIN_GOOD:  cfg_prdata = 32'(cfg_r.min_good);
      rgdf_pkg::REG_THRESHOLD: cfg_prdata = 32'(cfg_r.threshold);
      rgdf_pkg::REG_BAD_VALUE: cfg_prdata = 32'(unsigned'(cfg_r.bad_value));
      rgdf_pkg::REG_CLIP_GATE: cfg_prdata = 32'(cfg_r.clip_gate);
      default:                 cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.radius    <= rgdf_pkg::RST_RADIUS;
      cfg_r.min_good  <= rgdf_pkg::RST_MIN_GOOD;
      cfg_r.threshold <= rgdf_pkg::RST_THRESHOLD;
      cfg_r.bad_value <= rgdf_pkg::RST_BAD_VALUE;
      cfg_r.clip_gate <= rgdf_pkg::RST_CLIP_GATE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== src/rgdf_dev_test.sv =====
// Cross-multiplied outlier test of the window centre against the mean of the others.
`timescale 1ns / 1ps

module rgdf_dev_test #(
  parameter int CNT_W = 5,
  parameter int SUM_W = 21
) (
  input  logic signed [SUM_W-1:0] sum,
  input  logic [CNT_W-1:0]        good,
  input  logic signed [15:0]      centre,
  input  logic [15:0]             threshold,
  output logic                    exceed
);

  localparam int DW = SUM_W + 2;
  localparam int LW = 16 + CNT_W;

  logic signed [DW-1:0] c_x, g_x, s_x, prod, dev;
  logic [DW-1:0]        mag;
  logic [CNT_W-1:0]     good_m1;
  logic [LW-1:0]        lim;

  assign c_x  = {{(DW-16){centre[15]}}, centre};
  assign g_x  = signed'(DW'(good));
  assign s_x  = {{(DW-SUM_W){sum[SUM_W-1]}}, sum};
  assign prod = c_x * g_x;
  assign dev  = s_x - prod;
  assign mag  = dev[DW-1] ? unsigned'(-dev) : unsigned'(dev);

  // good is at least one whenever the result is used.
  assign good_m1 = good - CNT_W'(1);
  assign lim     = LW'(threshold) * LW'(good_m1);
  assign exceed  = mag > DW'(lim);

endmodule

// ===== src/rgdf_core.sv =====
// Window shift line, running sum and count, gate counter and glitch decision.
`timescale 1ns / 1ps

module rgdf_core #(
  parameter int MAX_RADIUS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rgdf_pkg::cfg_t     cfg,
  input  logic               radius_wr,
  input  logic               go,
  input  logic signed [15:0] sample,
  input  logic               in_boundary,
  input  logic               last_gate,
  output logic               glitch,
  output logic [15:0]        flagged_gate
);

  localparam int DEPTH = 2 * MAX_RADIUS + 1;
  localparam int RW    = $clog2(MAX_RADIUS + 1);
  localparam int IW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int SW    = 16 + CW;

  logic signed [15:0]    win_r [DEPTH];
  logic signed [15:0]    win_nxt [DEPTH];
  logic [CW-1:0]         fill_r, fill_nxt;
  logic [CW-1:0]         good_r, good_nxt;
  logic signed [SW-1:0]  sum_r, sum_nxt;
  logic [15:0]           gate_r, gate_nxt;

  logic [31:0]           rad_sel, rad_clamp, navg32, mg32, need32;
  logic [RW-1:0]         rad;
  logic [CW-1:0]         navg, need;
  logic [IW-1:0]         old_idx, ctr_idx;
  logic signed [15:0]    old_val, ctr_val;
  logic                  clip_ok, proc, full, old_good, new_good;
  logic                  test_ok, exceed, flag;
  logic [CW-1:0]         fill1, good1, good2;
  logic signed [SW-1:0]  sum1, sum2;

  // Effective radius: zero selects the default, then saturate.
  assign rad_sel   = (cfg.radius == '0) ? 32'(rgdf_pkg::DEFAULT_RADIUS) : 32'(cfg.radius);
  assign rad_clamp = (rad_sel > 32'(MAX_RADIUS)) ? 32'(MAX_RADIUS) : rad_sel;
  assign rad       = rad_clamp[RW-1:0];
  assign navg32    = 32'(2) * rad_clamp + 32'(1);
  assign navg      = navg32[CW-1:0];
  assign mg32      = 32'(cfg.min_good);
  assign need32    = (mg32 == '0 || mg32 > navg32) ? navg32 : mg32;
  assign need      = need32[CW-1:0];

  // Newest entry sits at the head of the line; the one leaving is 2r behind it,
  // the centre r-1 behind it before the shift.
  assign old_idx = IW'(navg32 - 32'(1));
  assign ctr_idx = IW'(rad_clamp - 32'(1));
  assign old_val = win_r[old_idx];
  assign ctr_val = win_r[ctr_idx];

  assign clip_ok  = gate_r < cfg.clip_gate;
  assign proc     = go && clip_ok && in_boundary;
  assign full     = fill_r >= navg;
  assign old_good = old_val != cfg.bad_value;
  assign new_good = sample != cfg.bad_value;

  always_comb begin
    sum1  = sum_r;
    good1 = good_r;
    if (full && old_good) begin
      sum1 = sum_r - {{(SW-16){old_val[15]}}, old_val};
      if (good_r != '0) begin
        good1 = good_r - CW'(1);
      end
    end
    fill1 = full ? navg : fill_r + CW'(1);
    sum2  = new_good ? sum1 + {{(SW-16){sample[15]}}, sample} : sum1;
    good2 = good1 + CW'(new_good);
  end

  assign test_ok = (fill1 == navg) && (good2 >= need) && (ctr_val != cfg.bad_value);

  rgdf_dev_test #(
    .CNT_W (CW),
    .SUM_W (SW)
  ) u_dev_test (
    .sum       (sum2),
    .good      (good2),
    .centre    (ctr_val),
    .threshold (cfg.threshold),
    .exceed    (exceed)
  );

  assign flag         = proc && test_ok && exceed;
  assign glitch       = flag;
  assign flagged_gate = flag ? gate_r - 16'(rad) : '0;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      win_nxt[i] = win_r[i];
    end
    if (proc) begin
      win_nxt[0] = sample;
      for (int i = 1; i < DEPTH; i++) begin
        win_nxt[i] = (flag && (i == int'(rad))) ? cfg.bad_value : win_r[i-1];
      end
    end
  end

  always_comb begin
    fill_nxt = fill_r;
    good_nxt = good_r;
    sum_nxt  = sum_r;
    gate_nxt = gate_r;
    if (radius_wr) begin
      fill_nxt = '0;
      good_nxt = '0;
      sum_nxt  = '0;
    end else if (go) begin
      if (clip_ok && !in_boundary) begin
        fill_nxt = '0;
        good_nxt = '0;
        sum_nxt  = '0;
      end else if (proc) begin
        fill_nxt = fill1;
        good_nxt = good2 - CW'(flag);
        sum_nxt  = flag ? sum2 - {{(SW-16){ctr_val[15]}}, ctr_val} : sum2;
      end
      if (gate_r != 16'hFFFF) begin
        gate_nxt = gate_r + 16'd1;
      end
      if (last_gate) begin
        fill_nxt = '0;
        good_nxt = '0;
        sum_nxt  = '0;
        gate_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      win_r[i] <= win_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      good_r <= '0;
      sum_r  <= '0;
      gate_r <= '0;
    end else begin
      fill_r <= fill_nxt;
      good_r <= good_nxt;
      sum_r  <= sum_nxt;
      gate_r <= gate_nxt;
    end
  end

endmodule

// ===== src/radar_gate_deglitch_flagger_unit.sv =====
// Top level of the radar gate deglitch flagger: stream ports, item registers and assertions.
`timescale 1ns / 1ps

// The block takes one radar gate per item and returns exactly one result item per gate. An
// accepted item is held in an input register; in the cycle it leaves that register the window
// is updated and the centre is tested, and the result is captured in the output register. A new
// item can be accepted in every cycle while the receiver takes results (one item per cycle
// sustained). The rate rests on a combinational window update: the running sum and count
// adjustment, two 16 by 5 bit multiplications and one magnitude compare.
// The window is a shift line of 2*MAX_RADIUS+1 sample registers; an effective window of
// 2*radius+1 taps is used, restarted at an unclipped gate outside the boundary, after the
// last gate of a ray and on a write to the radius register. The window needs no clearing
// after reset. A glitch result carries the ray index of the flagged centre gate in tdata;
// otherwise tdata is zero. Configuration must only be written while no item is in flight.
module radar_gate_deglitch_flagger_unit #(
  parameter int MAX_RADIUS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input items.
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [15:0]                     in_tdata,   // [15:0] sample
  input  logic                            in_tuser,   // [0] in_boundary
  input  logic                            in_tlast,   // last_gate
  // Result items.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [15:0]                     out_tdata,  // [15:0] flagged_gate
  output logic                            out_tuser,  // [0] glitch
  // Configuration port.
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [rgdf_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [rgdf_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [rgdf_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);

  rgdf_pkg::cfg_t     cfg;
  logic               radius_wr;

  logic               s1_valid_r, s1_valid_nxt;
  logic signed [15:0] s1_sample_r;
  logic               s1_inb_r, s1_last_r;
  logic               out_valid_r, out_valid_nxt;
  logic               out_glitch_r;
  logic [15:0]        out_gate_r;

  logic               in_acc, adv, go;
  logic               glitch;
  logic [15:0]        flagged_gate;

  rgdf_cfg_regs u_cfg_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg),
    .radius_wr   (radius_wr)
  );

  // The item in the input register moves on whenever the output register is free or emptying.
  assign adv       = !out_valid_r || out_tready;
  assign go        = s1_valid_r && adv;
  assign in_tready = !s1_valid_r || adv;
  assign in_acc    = in_tvalid && in_tready;

  rgdf_core #(
    .MAX_RADIUS (MAX_RADIUS)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .radius_wr    (radius_wr),
    .go           (go),
    .sample       (s1_sample_r),
    .in_boundary  (s1_inb_r),
    .last_gate    (s1_last_r),
    .glitch       (glitch),
    .flagged_gate (flagged_gate)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (go) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (go) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_sample_r <= in_tdata;
      s1_inb_r    <= in_tuser;
      s1_last_r   <= in_tlast;
    end
    if (go) begin
      out_glitch_r <= glitch;
      out_gate_r   <= flagged_gate;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_gate_r;
  assign out_tuser  = out_glitch_r;

  // An item leaving the input register always lands in the output register.
  a_go_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    go |=> out_valid_r)
    else $error("item left the input register without producing a result");

  // A gate outside the boundary can never be reported as a glitch.
  a_outside_no_glitch: assert property (@(posedge clk) disable iff (!rst_n)
    (go && !s1_inb_r) |=> !out_tuser)
    else $error("glitch reported for a gate outside the boundary");

  // A held item keeps its sample until it moves on.
  a_held_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !go) |=> (s1_valid_r && $stable(s1_sample_r)))
    else $error("held item lost or corrupted in the input register");

endmodule

// ===== sim/tb_radar_gate_deglitch_flagger_unit.sv =====
// Testbench for the radar gate deglitch flagger: predicts each result item and checks it.
`timescale 1ns / 1ps

module tb_radar_gate_deglitch_flagger_unit;

  localparam int WIN_MAX     = 8;
  localparam int HOLD_CYCLES = 4;

  typedef struct packed {
    logic [15:0] sample;
    logic        inb;
    logic        last;
  } radar_gate_t;

  typedef struct packed {
    logic        glitch;
    logic [15:0] gate;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // [15:0] sample
  logic        in_tuser = 1'b0; // [0] in_boundary
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // [15:0] flagged_gate
  logic        out_tuser;       // [0] glitch

  logic                            cfg_psel = 1'b0;
  logic                            cfg_penable = 1'b0;
  logic                            cfg_pwrite = 1'b0;
  logic [rgdf_pkg::CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [rgdf_pkg::CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [rgdf_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                            cfg_pready;

  // Items still to be offered and verdicts still to arrive.
  radar_gate_t gates_to_send[$];
  verdict_t    pending_verdicts[$];

  int   errors = 0;
  logic calm = 1'b0;      // set for the closing stretch: no idling on either side
  logic in_taken = 1'b0;  // an item was accepted at the last rising edge
  int   send_gap = 0;
  int   hold_off = 0;

  // Our own copy of the registers and of the window state.
  logic [3:0]  cur_radius = rgdf_pkg::RST_RADIUS;
  logic [4:0]  cur_min_good = rgdf_pkg::RST_MIN_GOOD;
  logic [15:0] cur_threshold = rgdf_pkg::RST_THRESHOLD;
  logic [15:0] cur_bad = rgdf_pkg::RST_BAD_VALUE;
  logic [15:0] cur_clip = rgdf_pkg::RST_CLIP_GATE;

  logic [15:0] win [0:2*WIN_MAX];
  int wr_slot = 0;
  int fill_cnt = 0;
  int good_cnt = 0;
  int win_sum = 0;
  int gate_idx = 0;

  radar_gate_deglitch_flagger_unit #(.MAX_RADIUS(WIN_MAX)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #1 clk = ~clk;

  // Empties the window; the gate index is left alone.
  function automatic void restart_window();
    wr_slot = 0;
    fill_cnt = 0;
    good_cnt = 0;
    win_sum = 0;
  endfunction

  // Advances the window by one gate and returns the verdict that gate should produce.
  function automatic verdict_t deglitch_gate(input logic [15:0] smp, input logic inb,
                                             input logic last);
    verdict_t    v;
    int          r, navg, need, slot, ctr, flagged;
    longint      c, dev, lim;
    logic [15:0] old;
    v = '0;
    r = (cur_radius == 4'd0) ? rgdf_pkg::DEFAULT_RADIUS : int'(cur_radius);
    if (r > WIN_MAX) r = WIN_MAX;
    navg = 2 * r + 1;
    need = (cur_min_good == 5'd0 || int'(cur_min_good) > navg) ? navg : int'(cur_min_good);
    if (gate_idx < int'(cur_clip)) begin
      if (!inb) begin
        restart_window();
      end else begin
        slot = wr_slot % navg;
        // A full window drops its oldest sample before the new one goes in.
        if (fill_cnt >= navg) begin
          old = win[slot];
          if (old != cur_bad) begin
            if (good_cnt > 0) good_cnt--;
            win_sum -= int'($signed(old));
          end
          fill_cnt = navg;
        end else begin
          fill_cnt++;
        end
        win[slot] = smp;
        if (smp != cur_bad) begin
          win_sum += int'($signed(smp));
          good_cnt++;
        end
        ctr = (slot + navg - r) % navg;
        if (fill_cnt == navg && good_cnt >= need && win[ctr] != cur_bad) begin
          // Centre against the mean of the others, multiplied out by the good count.
          c = longint'($signed(win[ctr]));
          dev = longint'(win_sum) - c * longint'(good_cnt);
          lim = longint'(cur_threshold) * (longint'(good_cnt) - 1);
          if (dev < 0) dev = -dev;
          if (dev > lim) begin
            win_sum -= int'(c);
            good_cnt--;
            win[ctr] = cur_bad;
            flagged = gate_idx - r;
            v.glitch = 1'b1;
            v.gate = flagged[15:0];
          end
        end
        wr_slot = (slot + 1) % navg;
      end
    end
    if (gate_idx < 65535) gate_idx++;
    if (last) begin
      restart_window();
      gate_idx = 0;
    end
    return v;
  endfunction

  // Sender: offers the head of the queue, holding it until it is taken, with random gaps.
  always @(negedge clk) begin : send_gates
    logic holding;
    holding = in_tvalid && !in_taken;
    if (in_taken) void'(gates_to_send.pop_front());
    if (!holding) begin
      if (send_gap > 0) begin
        send_gap--;
        in_tvalid <= 1'b0;
      end else if (gates_to_send.size() != 0 && !calm && $urandom_range(0, 5) == 0) begin
        send_gap = $urandom_range(0, 4);
        in_tvalid <= 1'b0;
      end else if (gates_to_send.size() != 0) begin
        in_tdata <= gates_to_send[0].sample;
        in_tuser <= gates_to_send[0].inb;
        in_tlast <= gates_to_send[0].last;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stalls in random bursts.
  always @(negedge clk) begin : stall_results
    if (hold_off > 0) begin
      hold_off--;
      out_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      hold_off = $urandom_range(0, 4);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Watches both channels at the rising edge. A result is checked before the item accepted
  // in the same cycle is predicted, since that item cannot have produced it yet.
  always @(posedge clk) begin : watch_streams
    verdict_t got, want;
    in_taken <= rst_n && in_tvalid && in_tready;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.glitch = out_tuser;
        got.gate = out_tdata;
        if (pending_verdicts.size() == 0) begin
          $error("unexpected result item: glitch %0d, flagged_gate %0d", got.glitch, got.gate);
          errors++;
        end else begin
          want = pending_verdicts.pop_front();
          if (got.glitch !== want.glitch) begin
            $error("glitch: expected %0d, got %0d", want.glitch, got.glitch);
            errors++;
          end
          if (got.gate !== want.gate) begin
            $error("flagged_gate: expected %0d, got %0d", want.gate, got.gate);
            errors++;
          end
        end
      end
      if (in_tvalid && in_tready)
        pending_verdicts.push_back(deglitch_gate(in_tdata, in_tuser, in_tlast));
    end
  end

  // One register write: a setup phase, then an access phase that completes on pready.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (idx)
      rgdf_pkg::REG_RADIUS: begin
        cur_radius = value[3:0];
        restart_window();
      end
      rgdf_pkg::REG_MIN_GOOD:  cur_min_good = value[4:0];
      rgdf_pkg::REG_THRESHOLD: cur_threshold = value[15:0];
      rgdf_pkg::REG_BAD_VALUE: cur_bad = value[15:0];
      rgdf_pkg::REG_CLIP_GATE: cur_clip = value[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic program_all(input logic [3:0] rad, input logic [4:0] mg, input logic [15:0] thr,
                             input logic [15:0] bad, input logic [15:0] clip);
    write_reg(rgdf_pkg::REG_RADIUS, {28'd0, rad});
    write_reg(rgdf_pkg::REG_MIN_GOOD, {27'd0, mg});
    write_reg(rgdf_pkg::REG_THRESHOLD, {16'd0, thr});
    write_reg(rgdf_pkg::REG_BAD_VALUE, {16'd0, bad});
    write_reg(rgdf_pkg::REG_CLIP_GATE, {16'd0, clip});
  endtask

  // Holds the stimulus back until every item has gone and every verdict has come home.
  task automatic drain();
    while (gates_to_send.size() != 0 || pending_verdicts.size() != 0) @(negedge clk);
    repeat (HOLD_CYCLES) @(negedge clk);
  endtask

  task automatic push_gate(input logic [15:0] smp, input logic inb, input logic last);
    radar_gate_t g;
    g.sample = smp;
    g.inb = inb;
    g.last = last;
    gates_to_send.push_back(g);
  endtask

  // One ray of gates around a random level, with spikes, sentinels and boundary gaps mixed in.
  task automatic queue_ray(input int len, input int amp, input int spike_pct, input int bad_pct,
                           input int oob_pct);
    int          base, t;
    logic [15:0] smp;
    base = $urandom_range(0, 65535);
    for (int i = 0; i < len; i++) begin
      t = base + int'($urandom_range(0, 2 * amp)) - amp;
      smp = t[15:0];
      if ($urandom_range(0, 99) < spike_pct) smp = 16'($urandom_range(0, 65535));
      if ($urandom_range(0, 99) < bad_pct) smp = cur_bad;
      push_gate(smp, $urandom_range(0, 99) >= oob_pct, i == len - 1);
    end
  endtask

  task automatic queue_rays(input int n, input int bad_pct, input int oob_pct);
    int queued, len, amp;
    queued = 0;
    while (queued < n) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 30);
      if (len > n - queued) len = n - queued;
      case ($urandom_range(0, 3))
        0: amp = 0;
        1: amp = $urandom_range(1, 32);
        2: amp = $urandom_range(33, 2000);
        default: amp = 32768;
      endcase
      queue_ray(len, amp, 8, bad_pct, oob_pct);
      queued += len;
    end
  endtask

  function automatic logic [15:0] pick_threshold();
    case ($urandom_range(0, 4))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(1, 64));
      default: return 16'($urandom_range(65, 3000));
    endcase
  endfunction

  function automatic logic [15:0] pick_bad();
    case ($urandom_range(0, 3))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  initial begin : stimulus
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: seven-gate window, whole window needed, any deviation flags.
    // A lone spike in the centre of a flat window is flagged.
    for (int i = 0; i < 7; i++) push_gate((i == 3) ? 16'd100 : 16'd0, 1'b1, 1'b0);
    // Field extremes, including the sentinel itself, slide through the full window.
    push_gate(16'h7FFF, 1'b1, 1'b0);
    push_gate(16'h8000, 1'b1, 1'b0);
    push_gate(16'h8001, 1'b1, 1'b0);
    push_gate(16'hFFFF, 1'b1, 1'b0);
    push_gate(16'h0001, 1'b1, 1'b0);
    // A gate outside the boundary restarts the window mid-ray.
    push_gate(16'h5555, 1'b0, 1'b0);
    push_gate(16'hAAAA, 1'b1, 1'b0);
    push_gate(16'h1234, 1'b1, 1'b1);
    // A flat ray after the restart: no deviation, so nothing is flagged.
    for (int i = 0; i < 7; i++) push_gate(16'h7FFF, 1'b1, i == 6);
    drain();

    // Three-gate window with clipping from gate four onwards.
    program_all(4'd1, 5'd0, 16'd0, 16'h8000, 16'd4);
    push_gate(16'd5, 1'b1, 1'b0);
    push_gate(16'd900, 1'b1, 1'b0);
    push_gate(16'd5, 1'b1, 1'b0);
    push_gate(16'd5, 1'b1, 1'b0);
    push_gate(16'd9000, 1'b1, 1'b0);
    push_gate(16'd5, 1'b1, 1'b1);
    drain();

    // Setting extremes first, then random settings; the last two phases run without idling.
    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0: program_all(4'd0, 5'd0, 16'd0, 16'h8000, 16'hFFFF);
        1: program_all(4'd8, 5'd1, 16'hFFFF, 16'h7FFF, 16'hFFFF);
        2: program_all(4'd15, 5'd17, 16'd50, 16'h0000, 16'd20);
        3: program_all(4'd1, 5'd31, 16'd10, 16'h8000, 16'd0);
        4: program_all(4'd2, 5'd1, 16'd0, pick_bad(), 16'hFFFF);
        5: program_all(4'd4, 5'd5, 16'd200, 16'h8000, 16'($urandom_range(3, 30)));
        default: program_all(4'($urandom_range(0, 15)), 5'($urandom_range(0, 31)),
                             pick_threshold(), pick_bad(), ($urandom_range(0, 2) == 0) ?
                             16'($urandom_range(0, 40)) : 16'hFFFF);
      endcase
      if (ph >= 10) calm = 1'b1;
      // Heavy sentinel use in one phase leaves windows with a single good sample.
      if (ph == 4) queue_rays(90, 45, 5);
      else if (ph == 3) queue_rays(30, 8, 5);
      else queue_rays(90, 8, 5);
      drain();
    end

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    #6_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
